// File: design/bval_pkg.sv
// ----------------------------------------------------------------------------
// bval_pkg
// Shared types and constants of the battery voltage averaging block:
// register indexes, reset values, fixed field widths and scaling constants.
// ----------------------------------------------------------------------------
package bval_pkg;

  // register indexes of the configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_MV   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_MV   = 2'd2;

  // field widths
  localparam int WLEN_W = 7;
  localparam int LIM_W  = 16;
  localparam int CFG_W  = 16;
  localparam int BMV_W  = 13;
  localparam int PCT_W  = 7;

  // register reset values
  localparam logic [WLEN_W-1:0] WINDOW_LEN_RST = 7'd8;
  localparam logic [LIM_W-1:0]  UPPER_MV_RST   = 16'd4200;
  localparam logic [LIM_W-1:0]  LOWER_MV_RST   = 16'd3300;

  // converter gain 0.8059 mV per count
  localparam int MV_NUM = 8059;
  localparam int MV_DEN = 10000;
  // extra fraction bits of the gain reciprocal beyond the sample width,
  // 2**14 above the denominator keeps the truncated product exact
  localparam int MV_GUARD = 14;

  // divider ratio 105/50
  localparam int DIV_NUM = 105;
  localparam int DIV_DEN = 50;
  // ratio as a rounded-up 16-bit fraction, exact for any 12-bit average
  localparam int SCL_SHIFT = 16;
  localparam int SCL_MUL   = ((DIV_NUM << SCL_SHIFT) + DIV_DEN - 1) / DIV_DEN;
  localparam int SCL_MUL_W = 18;

  localparam int MV_MAX  = 8191;
  localparam int PCT_MAX = 100;

  // quotient lengths of the serial divisions
  localparam int AVG_QW = 12;
  localparam int PCT_QW = PCT_W;

  // smallest average whose scaled value no longer fits the output field
  localparam int AVG_SAT_MIN = ((MV_MAX + 1) * DIV_DEN + DIV_NUM - 1) / DIV_NUM;

  // percentage numerator: 100 times a 16-bit magnitude
  localparam int PNUM_W = LIM_W + 7;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

// File: design/battery_voltage_average_and_level.sv
// ----------------------------------------------------------------------------
// battery_voltage_average_and_level
// Converts raw converter samples to millivolts, keeps a moving average over
// a sample store with warm-up, scales it for the divider and derives a
// clamped charge percentage between two configurable limits.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                     | direction
//  ---------+---------------------------------------------+----------
//  in       | in_valid_i, in_ready_o, raw_sample_i        | sink
//  out      | out_valid_o, out_ready_i, battery_mv_o,     | source
//           | charge_pct_o                                |
//  cfg      | cfg_valid_i, cfg_ready_o, cfg_index_i,      | sink
//           | cfg_data_i                                  |
//
//  One item at a time: a sample is taken only in the idle state, the next
//  only after the last result has gone to the output register. Quotients
//  come from the one-bit-per-cycle divider (12 steps for the average, 7 for
//  the percentage); gain and divider scaling are reciprocal multiplications.
//  A charge level that is zero without a quotient skips the percentage
//  division. After reset the sample store is cleared one entry per cycle,
//  with in_ready_o low; configuration writes are taken throughout.
//  A finished result waits in the output register; the next sample is
//  accepted meanwhile, and only the hand-over of a later result stalls.
//
module battery_voltage_average_and_level #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [SAMPLE_BITS-1:0]         raw_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bval_pkg::BMV_W-1:0]     battery_mv_o,
  output logic [bval_pkg::PCT_W-1:0]     charge_pct_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bval_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bval_pkg::CFG_W-1:0]     cfg_data_i
);
  import bval_pkg::*;

  // derived widths
  localparam int IDX_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
  localparam int EW       = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
  localparam int SUM_W    = SAMPLE_BITS + CNT_W;
  localparam int MV_SHIFT = SAMPLE_BITS + MV_GUARD;
  localparam int PROD_W   = SAMPLE_BITS + MV_SHIFT;
  localparam longint MV_MUL = ((longint'(MV_NUM) << MV_SHIFT) + MV_DEN - 1) / MV_DEN;
  localparam int SPROD_W  = AVG_QW + SCL_MUL_W;
  localparam int DW_A     = (SUM_W > CNT_W + AVG_QW) ? SUM_W : CNT_W + AVG_QW;
  localparam int DW       = (DW_A > PNUM_W) ? DW_A : PNUM_W;
  localparam int QUO_W    = (AVG_QW > PCT_QW) ? AVG_QW : PCT_QW;
  localparam int STEP_W   = $clog2(QUO_W + 1);
  localparam longint MVV_MAX = ((longint'(2) ** SAMPLE_BITS - 1) * MV_NUM) / MV_DEN;
  localparam logic [SUM_W-1:0] SUM_LIM = SUM_W'(longint'(MAX_WINDOW) * MVV_MAX);

  // sequencer states
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_UPD   = 4'd2;
  localparam logic [3:0] ST_AGO   = 4'd3;
  localparam logic [3:0] ST_AVG   = 4'd4;
  localparam logic [3:0] ST_PRE   = 4'd5;
  localparam logic [3:0] ST_PGO   = 4'd6;
  localparam logic [3:0] ST_PCT   = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0]             state_q, state_d;

  logic [WLEN_W-1:0]      win_len_q;
  logic [LIM_W-1:0]       upper_q;
  logic [LIM_W-1:0]       lower_q;

  logic [SAMPLE_BITS-1:0] store_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;

  logic [IDX_W-1:0]       clr_q;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   full_q, full_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [CNT_W-1:0]       dcnt_q, dcnt_d;
  logic [SAMPLE_BITS-1:0] mv_q;

  logic [BMV_W-1:0]       bmv_q, bmv_d;
  logic [PCT_W-1:0]       pct_q, pct_d;
  logic [PNUM_W-1:0]      pnum_q;
  logic [LIM_W-1:0]       pden_q;
  logic                   pzero_q;

  logic                   out_valid_q;
  logic [BMV_W-1:0]       out_mv_q;
  logic [PCT_W-1:0]       out_pct_q;
  logic                   out_load;

  logic                   div_start;
  logic [DW-1:0]          div_dvd;
  logic [DW-1:0]          div_dvs;
  logic [STEP_W-1:0]      div_steps;
  logic [QUO_W-1:0]       div_quo;
  div_stat_t              div_stat;

  logic [EW-1:0]          len_e;
  logic [CNT_W-1:0]       w_eff;
  logic [CNT_W-1:0]       cnt_next;
  logic [PROD_W-1:0]      mv_prod;
  logic [SAMPLE_BITS-1:0] mv_new;
  logic [AVG_QW-1:0]      avg;
  logic                   avg_sat;
  logic [SPROD_W-1:0]     scl_prod;
  logic signed [LIM_W+1:0] pdiff;
  logic signed [LIM_W:0]   pden_s;
  logic [LIM_W+1:0]       pdiff_neg;
  logic [LIM_W:0]         pden_neg;
  logic [LIM_W-1:0]       diff_mag;
  logic [LIM_W-1:0]       den_mag;
  logic                   pzero_d;
  logic [PCT_QW-1:0]      pct_quo;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= WINDOW_LEN_RST;
      upper_q   <= UPPER_MV_RST;
      lower_q   <= LOWER_MV_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WINDOW_LEN: win_len_q <= cfg_data_i[WLEN_W-1:0];
        REG_UPPER_MV:   upper_q   <= cfg_data_i[LIM_W-1:0];
        REG_LOWER_MV:   lower_q   <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // effective window: zero acts as one, clipped to the store depth
  assign len_e = EW'(win_len_q);
  always_comb begin
    if (len_e == '0) begin
      w_eff = CNT_W'(1);
    end else if (len_e > EW'(MAX_WINDOW)) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = len_e[CNT_W-1:0];
    end
  end

  // sample store, read-modify-write over one item
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= store_mem[idx_q];
  end

  // datapath helpers
  // gain as a rounded-up reciprocal product, the truncated top bits are exact
  assign mv_prod   = PROD_W'(raw_sample_i) * PROD_W'(MV_MUL);
  assign mv_new    = mv_q;
  assign cnt_next  = CNT_W'(idx_q) + CNT_W'(1);
  assign avg       = div_quo[AVG_QW-1:0];
  assign avg_sat   = div_stat.ovf || (avg >= AVG_QW'(AVG_SAT_MIN));
  assign scl_prod  = SPROD_W'(avg) * SPROD_W'(SCL_MUL);
  assign pct_quo   = div_quo[PCT_QW-1:0];

  // signed distance to the lower limit and the limit span
  assign pdiff     = $signed({{(LIM_W + 2 - BMV_W){1'b0}}, bmv_q})
                   - $signed({2'b00, lower_q});
  assign pden_s    = $signed({1'b0, upper_q}) - $signed({1'b0, lower_q});
  assign pdiff_neg = -pdiff;
  assign pden_neg  = -pden_s;
  assign diff_mag  = pdiff[LIM_W+1] ? pdiff_neg[LIM_W-1:0] : pdiff[LIM_W-1:0];
  assign den_mag   = pden_s[LIM_W] ? pden_neg[LIM_W-1:0] : pden_s[LIM_W-1:0];
  // equal limits, zero distance or opposite signs give a quotient of at most zero
  assign pzero_d   = (pden_s == '0) || (pdiff == '0) || (pdiff[LIM_W+1] != pden_s[LIM_W]);

  // sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    full_d    = full_q;
    sum_d     = sum_q;
    dcnt_d    = dcnt_q;
    bmv_d     = bmv_q;
    pct_d     = pct_q;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = mv_new;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    div_steps = '0;
    out_load  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == IDX_W'(MAX_WINDOW - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // millivolt value is registered on the input transfer
        if (in_valid_i) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        // replace the oldest entry and advance the write index
        mem_we = 1'b1;
        sum_d  = sum_q - SUM_W'(rd_q) + SUM_W'(mv_new);
        if (cnt_next >= w_eff) begin
          idx_d  = '0;
          full_d = 1'b1;
        end else begin
          idx_d = cnt_next[IDX_W-1:0];
        end
        dcnt_d  = full_q ? w_eff : cnt_next;
        state_d = ST_AGO;
      end
      ST_AGO: begin
        div_start = 1'b1;
        div_dvd   = DW'(sum_q);
        div_dvs   = DW'(dcnt_q) << (AVG_QW - 1);
        div_steps = STEP_W'(AVG_QW);
        state_d   = ST_AVG;
      end
      ST_AVG: begin
        // divider scaling by reciprocal product, saturated at the field limit
        if (div_stat.done) begin
          if (avg_sat) begin
            bmv_d = BMV_W'(MV_MAX);
          end else begin
            bmv_d = scl_prod[SCL_SHIFT+BMV_W-1:SCL_SHIFT];
          end
          state_d = ST_PRE;
        end
      end
      ST_PRE: begin
        state_d = ST_PGO;
      end
      ST_PGO: begin
        if (pzero_q) begin
          pct_d   = '0;
          state_d = ST_OUT;
        end else begin
          div_start = 1'b1;
          div_dvd   = DW'(pnum_q);
          div_dvs   = DW'(pden_q) << (PCT_QW - 1);
          div_steps = STEP_W'(PCT_QW);
          state_d   = ST_PCT;
        end
      end
      ST_PCT: begin
        if (div_stat.done) begin
          if (div_stat.ovf || pct_quo > PCT_QW'(PCT_MAX)) begin
            pct_d = PCT_W'(PCT_MAX);
          end else begin
            pct_d = pct_quo;
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      idx_q   <= '0;
      full_q  <= 1'b0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + IDX_W'(1);
      end
      idx_q  <= idx_d;
      full_q <= full_d;
      sum_q  <= sum_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    dcnt_q <= dcnt_d;
    bmv_q  <= bmv_d;
    pct_q  <= pct_d;
    if (in_valid_i && in_ready_o) begin
      mv_q <= mv_prod[PROD_W-1:MV_SHIFT];
    end
    if (state_q == ST_PRE) begin
      pnum_q  <= PNUM_W'(diff_mag) * PNUM_W'(PCT_MAX);
      pden_q  <= den_mag;
      pzero_q <= pzero_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mv_q  <= bmv_q;
      out_pct_q <= pct_q;
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign battery_mv_o = out_mv_q;
  assign charge_pct_o = out_pct_q;

  // shared divider
  bval_div #(
    .DW     (DW),
    .QW     (QUO_W),
    .STEP_W (STEP_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .steps_i    (div_steps),
    .quo_o      (div_quo),
    .stat_o     (div_stat)
  );

  // once the window has filled, warm-up never comes back
  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("window full flag dropped");

  // running sum stays within what the store can hold
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SUM_LIM)
    else $error("running sum out of range");

  // divider completions only arrive while the sequencer waits for one
  a_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_AVG || state_q == ST_PCT))
    else $error("divider result in an unexpected state");

  // a presented charge level is a percentage
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> charge_pct_o <= PCT_W'(PCT_MAX))
    else $error("charge level above one hundred");

endmodule

// File: design/bval_div.sv
// ----------------------------------------------------------------------------
// bval_div
// Restoring divider, one quotient bit per cycle. The caller passes the
// divisor already shifted left by (steps - 1); an overflow flag tells when
// the quotient does not fit in the requested number of bits.
// ----------------------------------------------------------------------------
module bval_div #(
  parameter int DW     = 30,
  parameter int QW     = 16,
  parameter int STEP_W = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DW-1:0]        dividend_i,
  input  logic [DW-1:0]        divisor_i,
  input  logic [STEP_W-1:0]    steps_i,
  output logic [QW-1:0]        quo_o,
  output bval_pkg::div_stat_t  stat_o
);
  import bval_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic              ovf_q;
  logic [DW-1:0]     rem_q;
  logic [DW-1:0]     dsh_q;
  logic [QW-1:0]     quo_q;
  logic [STEP_W-1:0] cnt_q;
  logic              ge;
  logic              ovf_d;

  // trial subtraction and overflow check on the aligned divisor
  assign ge    = rem_q >= dsh_q;
  assign ovf_d = {1'b0, dividend_i} >= {divisor_i, 1'b0};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dsh_q <= divisor_i;
      quo_q <= '0;
      cnt_q <= steps_i;
      ovf_q <= ovf_d;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[QW-2:0], ge};
      dsh_q <= dsh_q >> 1;
      cnt_q <= cnt_q - STEP_W'(1);
    end
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;

  // a new division never starts on top of a running one
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  // completion is a single pulse that ends the busy phase
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a preceding busy phase");

  // the step count never runs out while busy
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider busy with zero steps left");

endmodule

// File: sim/battery_level_checker.sv
// ----------------------------------------------------------------------------
// battery_level_checker
// Watches the sample, result and register channels of the battery averaging
// block. It keeps its own copy of the sample store, the running sum and the
// registers, works out the averaged voltage and charge level of every sample
// transfer, and compares each result transfer with the oldest expected one.
// ----------------------------------------------------------------------------
module battery_level_checker #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [SAMPLE_BITS-1:0]         raw_sample_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [bval_pkg::BMV_W-1:0]     battery_mv_i,
  input  logic [bval_pkg::PCT_W-1:0]     charge_pct_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [bval_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bval_pkg::CFG_W-1:0]     cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);

  // converter gain 0.8059 mV per count, divider ratio 105/50
  localparam int unsigned GAIN_NUM    = 8059;
  localparam int unsigned GAIN_DEN    = 10000;
  localparam int unsigned DIVIDER_NUM = 105;
  localparam int unsigned DIVIDER_DEN = 50;
  localparam int unsigned MV_CEIL     = 8191;
  localparam int unsigned PCT_CEIL    = 100;
  localparam int          SUM_W       = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;

  // register values after reset
  localparam logic [6:0]  WINDOW_RST = 7'd8;
  localparam logic [15:0] UPPER_RST  = 16'd4200;
  localparam logic [15:0] LOWER_RST  = 16'd3300;

  typedef struct packed {
    logic [bval_pkg::BMV_W-1:0] mv;
    logic [bval_pkg::PCT_W-1:0] pct;
  } reading_t;

  // sample history and running sum
  logic [SAMPLE_BITS-1:0] mv_store [MAX_WINDOW];
  logic [SUM_W-1:0]       running_total;
  logic [6:0]             write_pos;
  logic                   warmed_up;

  // register copies
  logic [6:0]  window_reg;
  logic [15:0] upper_reg;
  logic [15:0] lower_reg;

  reading_t expected_readings [$];
  int       fails   = 0;
  int       waiting = 0;
  int       checked = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;
  assign checked_o    = checked;

  function automatic void clear_model();
    foreach (mv_store[i]) mv_store[i] = '0;
    running_total = '0;
    write_pos     = '0;
    warmed_up     = 1'b0;
    window_reg    = WINDOW_RST;
    upper_reg     = UPPER_RST;
    lower_reg     = LOWER_RST;
    expected_readings.delete();
    waiting = 0;
  endfunction

  // moving average with warm-up, divider scaling and clamped charge level
  function automatic reading_t average_and_level(input logic [SAMPLE_BITS-1:0] raw);
    reading_t    r;
    int unsigned mv;
    int unsigned span;
    int unsigned pos;
    int unsigned avg;
    int unsigned scaled;
    longint      span_mv;
    longint      lo;
    longint      q;
    mv   = raw;
    mv   = mv * GAIN_NUM / GAIN_DEN;
    span = window_reg;
    if (span == 0) span = 1;
    if (span > MAX_WINDOW) span = MAX_WINDOW;
    pos = write_pos;
    if (pos >= MAX_WINDOW) pos = 0;
    if (!warmed_up) begin
      // warm-up: average over the samples taken so far
      mv_store[pos] = mv[SAMPLE_BITS-1:0];
      running_total = SUM_W'(running_total + mv);
      pos++;
      avg = running_total / pos;
      if (pos >= span) begin
        pos       = 0;
        warmed_up = 1'b1;
      end
    end else begin
      // full window: replace the oldest entry, stale ones stay summed
      running_total = SUM_W'(running_total - mv_store[pos] + mv);
      mv_store[pos] = mv[SAMPLE_BITS-1:0];
      pos++;
      if (pos >= span) pos = 0;
      avg = running_total / span;
    end
    write_pos = pos[6:0];

    scaled = avg * DIVIDER_NUM / DIVIDER_DEN;
    if (scaled > MV_CEIL) scaled = MV_CEIL;
    r.mv = scaled[bval_pkg::BMV_W-1:0];

    // signed percentage between the limits
    span_mv = upper_reg;
    lo      = lower_reg;
    span_mv = span_mv - lo;
    if (span_mv == 0) begin
      r.pct = '0;
    end else begin
      q = (longint'(PCT_CEIL) * (longint'(scaled) - lo)) / span_mv;
      if (q > longint'(PCT_CEIL)) q = longint'(PCT_CEIL);
      if (q < 0) q = 0;
      r.pct = q[bval_pkg::PCT_W-1:0];
    end
    return r;
  endfunction

  // register writes, result checks, then new expectations
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          bval_pkg::REG_WINDOW_LEN: window_reg = cfg_data_i[6:0];
          bval_pkg::REG_UPPER_MV:   upper_reg  = cfg_data_i;
          bval_pkg::REG_LOWER_MV:   lower_reg  = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: result with nothing expected: battery_mv %0d charge_pct %0d",
                   $time, battery_mv_i, charge_pct_i);
          fails++;
        end else begin
          want = expected_readings.pop_front();
          if (battery_mv_i !== want.mv) begin
            $display("%0t: battery_mv mismatch: expected %0d, actual %0d",
                     $time, want.mv, battery_mv_i);
            fails++;
          end
          if (charge_pct_i !== want.pct) begin
            $display("%0t: charge_pct mismatch: expected %0d, actual %0d",
                     $time, want.pct, charge_pct_i);
            fails++;
          end
          checked++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_readings.push_back(average_and_level(raw_sample_i));
      end
      waiting = expected_readings.size();
    end
  end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for the battery voltage averaging block. A directed part walks
// through warm-up, window shrink and resize, saturation and odd limit pairs;
// then random phases with fresh register settings push random samples with
// random gaps and result stalls. A checker beside the block predicts and
// compares every result; a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 12;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 120;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 50;
  localparam logic [SAMPLE_BITS-1:0] RAW_MAX = '1;
  localparam logic [bval_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [SAMPLE_BITS-1:0]         raw_sample_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [bval_pkg::BMV_W-1:0]     battery_mv_o;
  logic [bval_pkg::PCT_W-1:0]     charge_pct_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [bval_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [bval_pkg::CFG_W-1:0]     cfg_data_i;

  int fail_count;
  int pending;
  int checked;
  int samples_sent     = 0;
  int settings_applied = 0;
  int quiet_cycles     = 0;
  bit gaps_enabled     = 1'b0;

  // clock, period 4
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  battery_voltage_average_and_level #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .raw_sample_i(raw_sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .battery_mv_o(battery_mv_o),
    .charge_pct_o(charge_pct_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  battery_level_checker #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .raw_sample_i(raw_sample_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .battery_mv_i(battery_mv_o),
    .charge_pct_i(charge_pct_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("battery_voltage_average_and_level regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: ready with random stall bursts
  initial begin : result_sink
    int hold;
    hold        = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold        = hold - 1;
        out_ready_i <= 1'b0;
      end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
        hold        = $urandom_range(0, 18);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // one sample transfer, valid stays high for back-to-back samples
  task automatic push_sample(input logic [SAMPLE_BITS-1:0] raw);
    if (gaps_enabled && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_sample_i <= raw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    samples_sent++;
  endtask

  task automatic write_register(input logic [bval_pkg::CFG_IDX_W-1:0] idx,
                                input logic [bval_pkg::CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // let every result drain, then load a new register setting
  task automatic reconfigure(input logic [bval_pkg::CFG_W-1:0] window_data,
                             input logic [15:0] upper_mv,
                             input logic [15:0] lower_mv,
                             input bit touch_unused);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    if (touch_unused) write_register(REG_UNUSED, 16'hFFFF);
    write_register(bval_pkg::REG_WINDOW_LEN, window_data);
    write_register(bval_pkg::REG_UPPER_MV, upper_mv);
    write_register(bval_pkg::REG_LOWER_MV, lower_mv);
    cfg_valid_i <= 1'b0;
    settings_applied++;
  endtask

  initial begin : stimulus
    logic [SAMPLE_BITS-1:0] warmup_set [10];
    logic [SAMPLE_BITS-1:0] raw;
    logic [6:0]             win;
    logic [15:0]            up;
    logic [15:0]            lo;
    int                     pick;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    raw_sample_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = bval_pkg::REG_WINDOW_LEN;
    cfg_data_i   = '0;
    warmup_set   = '{RAW_MAX, 12'd0, 12'd2048, 12'd1365, 12'd2730,
                     RAW_MAX, RAW_MAX, RAW_MAX, RAW_MAX, 12'd1};
    repeat (8) @(negedge clk_i);
    rst_ni       <= 1'b1;
    gaps_enabled = 1'b1;

    // warm-up and first full window at the reset settings
    foreach (warmup_set[i]) push_sample(warmup_set[i]);

    // shrink to one entry: stale entries keep the sum high, output saturates
    reconfigure(16'd1, 16'd5000, 16'd5000, 1'b0);
    push_sample(RAW_MAX);
    push_sample(12'd0);

    // zero window acts as one, upper limit below lower
    reconfigure(16'hFF80, 16'h0000, 16'hFFFF, 1'b0);
    push_sample(RAW_MAX);
    push_sample(12'd1000);

    // oversized window acts as the maximum, widest span, unused index
    reconfigure(16'h5A7F, 16'hFFFF, 16'h0000, 1'b1);
    push_sample(RAW_MAX);
    push_sample(12'd0);
    push_sample(12'd2222);

    // full window length, one millivolt span
    reconfigure(16'd64, 16'd3000, 16'd2999, 1'b0);
    push_sample(12'd2000);
    push_sample(12'd1999);

    // random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       win = 7'd0;
        1:       win = 7'($urandom_range(65, 127));
        2:       win = 7'd64;
        3:       win = 7'd1;
        default: win = 7'($urandom_range(2, 63));
      endcase
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          lo = 16'($urandom());
          up = lo;
        end
        1: begin
          up = 16'($urandom_range(0, 4000));
          lo = up + 16'($urandom_range(1, 3000));
        end
        2: begin
          up = 16'($urandom());
          lo = 16'($urandom());
        end
        default: begin
          lo = 16'($urandom_range(2500, 3600));
          up = lo + 16'($urandom_range(1, 2500));
        end
      endcase
      reconfigure({9'($urandom_range(0, 511)), win}, up, lo, 1'b0);
      gaps_enabled = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          raw = SAMPLE_BITS'($urandom_range(0, RAW_MAX));
        end else if (pick < 8) begin
          raw = SAMPLE_BITS'($urandom_range(1950, 2490));
        end else if (pick == 8) begin
          raw = ($urandom_range(0, 1) == 0) ? RAW_MAX : '0;
        end else begin
          raw = SAMPLE_BITS'($urandom_range(0, 63));
        end
        push_sample(raw);
      end
    end

    // drain and settle
    in_valid_i   <= 1'b0;
    gaps_enabled = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("summary: %0d samples over %0d register settings, %0d results checked",
             samples_sent, settings_applied + 1, checked);
    $display("summary: warm-up, window shrink and growth, saturation, equal, reversed "
             , "and random limits, with random gaps and stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("battery_voltage_average_and_level regression: pass");
    end else begin
      $display("battery_voltage_average_and_level regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
design/bval_pkg.sv
design/bval_div.sv
design/battery_voltage_average_and_level.sv
sim/battery_level_checker.sv
sim/tb.sv
